/* design/i2a_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg: integer to ASCII formatter package
// Shared payload types, character codes, mode codes, controller state and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned IN_VALUE_W = 32;
  localparam int unsigned CHAR_W = 8;

  localparam logic [MODE_W-1:0] MODE_UDEC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SDEC = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HEX = 2'd2;
  // Bit of mode that selects hexadecimal (the unused code also prints hex).
  localparam int unsigned MODE_HEX_BIT = 1;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_A_BASE = CHAR_A - 8'd10;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [IN_VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] text_char;
    logic              last_char;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic hex;
    logic neg;
    logic dabble_done;
    logic top_zero;
    logic left_one;
    logic out_free;
  } sts_t;

endpackage

/* design/i2a_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_ctrl: formatter controller
// Sequences load, binary-to-BCD conversion, leading-zero skip, sign and
// character output by commands to the datapath.
// ----------------------------------------------------------------------------
module i2a_ctrl import i2a_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (sts_i.hex || sts_i.dabble_done) begin
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (!sts_i.top_zero || sts_i.left_one) begin
          state_d = sts_i.neg ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (sts_i.out_free) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free && sts_i.left_one) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_CONVERT: cmd_o.dabble = !sts_i.hex && !sts_i.dabble_done;
      ST_SKIP:    cmd_o.skip = sts_i.top_zero && !sts_i.left_one;
      ST_SIGN:    cmd_o.emit_sign = sts_i.out_free;
      ST_EMIT:    cmd_o.emit_digit = sts_i.out_free;
      default:    cmd_o = '0;
    endcase
  end

endmodule

/* design/i2a_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_dpath: formatter datapath
// Holds the magnitude, the digit shift register (BCD or hex nibbles, most
// significant at the top), the counters and the output register.
// ----------------------------------------------------------------------------
module i2a_dpath import i2a_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [MODE_W-1:0]     mode_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o
);

  // Decimal digit count: floor(N * log10(2)) + 1
  localparam int unsigned DEC_DIGITS = ((VALUE_BITS * 1233) >> 12) + 1;
  localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int unsigned DIG_W = 4 * DEC_DIGITS;
  localparam int unsigned HEX_W = 4 * HEX_DIGITS;
  localparam int unsigned LEFT_W = $clog2(DEC_DIGITS + 1);
  localparam int unsigned BIT_CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [DIG_W-1:0]      digits_q, digits_d;
  logic [LEFT_W-1:0]     left_q, left_d;
  logic [BIT_CNT_W-1:0]  bit_cnt_q, bit_cnt_d;
  logic                  hex_q, hex_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic                  in_neg;
  logic [DIG_W-1:0]      dabble_adj;
  logic [3:0]            top_digit;
  logic                  out_free;

  assign top_digit = digits_q[DIG_W-1 -: 4];
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_neg = (mode_i == MODE_SDEC) && value_i[VALUE_BITS-1];

  // Add 3 to every BCD digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (digits_q[4*i +: 4] >= 4'd5) begin
        dabble_adj[4*i +: 4] = digits_q[4*i +: 4] + 4'd3;
      end else begin
        dabble_adj[4*i +: 4] = digits_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_d = mag_q;
    digits_d = digits_q;
    left_d = left_q;
    bit_cnt_d = bit_cnt_q;
    hex_d = hex_q;
    neg_d = neg_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.load) begin
      hex_d = mode_i[MODE_HEX_BIT];
      neg_d = !mode_i[MODE_HEX_BIT] && in_neg;
      mag_d = in_neg ? (~value_i + 1'b1) : value_i;
      bit_cnt_d = BIT_CNT_W'(VALUE_BITS);
      if (mode_i[MODE_HEX_BIT]) begin
        digits_d = DIG_W'(HEX_W'(value_i)) << (DIG_W - HEX_W);
        left_d = LEFT_W'(HEX_DIGITS);
      end else begin
        digits_d = '0;
        left_d = LEFT_W'(DEC_DIGITS);
      end
    end

    if (cmd_i.dabble) begin
      digits_d = {dabble_adj[DIG_W-2:0], mag_q[VALUE_BITS-1]};
      mag_d = mag_q << 1;
      bit_cnt_d = bit_cnt_q - 1'b1;
    end

    if (cmd_i.skip || cmd_i.emit_digit) begin
      digits_d = digits_q << 4;
      left_d = left_q - 1'b1;
    end

    if (cmd_i.emit_sign) begin
      out_d.text_char = CHAR_MINUS;
      out_d.last_char = 1'b0;
      out_valid_d = 1'b1;
    end

    if (cmd_i.emit_digit) begin
      if (top_digit < 4'd10) begin
        out_d.text_char = CHAR_ZERO + {4'b0, top_digit};
      end else begin
        out_d.text_char = CHAR_A_BASE + {4'b0, top_digit};
      end
      out_d.last_char = (left_q == LEFT_W'(1));
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      left_q <= '0;
      bit_cnt_q <= '0;
      hex_q <= 1'b0;
      neg_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      left_q <= left_d;
      bit_cnt_q <= bit_cnt_d;
      hex_q <= hex_d;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    digits_q <= digits_d;
    out_q <= out_d;
  end

  always_comb begin
    sts_o.hex = hex_q;
    sts_o.neg = neg_q;
    sts_o.dabble_done = (bit_cnt_q == '0);
    sts_o.top_zero = (top_digit == 4'd0);
    sts_o.left_one = (left_q == LEFT_W'(1));
    sts_o.out_free = out_free;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

endmodule

/* design/integer_to_ascii_formatter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter: integer to ASCII text
// Prints one value per transfer as unsigned decimal, signed decimal or
// uppercase hex, one character per output transfer, most significant first.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Payload
//  --------+------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o| in_data_i  {mode, value}
//  out     | out_valid_o/ out_stall_i| out_data_o {text_char, last_char}
//
// Steps per value: accept; the converter state, which hex passes straight
// through and decimal uses for one shift-and-add-3 step per bit; skip of
// leading zero digits or nibbles (the last one is always printed); a minus
// sign for a negative signed decimal value; then the remaining digits or
// nibbles, printed one per output transfer.
// Reset clears the controller and the output valid; no clearing pass.
// Output stalls hold the character register and pause the controller; a new
// value is taken once the last character has been moved into the output
// register, even while it still waits for its transfer.
//
module integer_to_ascii_formatter import i2a_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cmd_t                  cmd;
  sts_t                  sts;
  logic [VALUE_BITS-1:0] value_in;

  // Fit the input word to the working width: drop high bits or zero-extend.
  if (VALUE_BITS <= IN_VALUE_W) begin : g_trunc
    assign value_in = in_data_i.value[VALUE_BITS-1:0];
  end else begin : g_ext
    assign value_in = {{(VALUE_BITS - IN_VALUE_W){1'b0}}, in_data_i.value};
  end

  i2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  i2a_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (in_data_i.mode),
    .value_i     (value_in),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
